FILE: rtl/pid_controller_clamped_unit_macros.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared assertion forms for the clamped PID controller.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define PIDC_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pidc assertion failed: same-cycle check");

// The condition implies the consequence in the next cycle.
`define PIDC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pidc assertion failed: next-cycle check");

`endif

FILE: rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, microcode word layout and the control program.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int TS_W      = DATA_W - 1;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 4;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MODE = 3'd6;

   localparam logic MODE_ABSOLUTE = 1'b0;

   localparam logic [TS_W-1:0] TIME_STEP_RESET = TS_W'(65536);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [PC_W-1:0] PC_INTEG = 4'd4;
   localparam logic [PC_W-1:0] PC_LAST  = 4'd12;

   typedef enum logic [2:0] {
      A_ZERO, A_TGT, A_ERR, A_INTEG, A_ACC, A_MEAS_OR_ZERO
   } src_a_type;

   typedef enum logic [2:0] {
      B_ZERO, B_MEAS, B_PREV, B_FX, B_PTERM, B_ITERM, B_DERIV
   } src_b_type;

   typedef enum logic [2:0] {
      D_NONE, D_ERR, D_DIFF, D_INTEG, D_ACC
   } dst_type;

   typedef enum logic [2:0] {
      M_NONE, M_P_ERR, M_ERR_TS, M_D_DIFF, M_I_INTEG
   } mul_sel_type;

   typedef enum logic [1:0] {
      F_NONE, F_PTERM, F_ITERM
   } fx_dst_type;

   typedef enum logic [1:0] {
      S_NEXT, S_WAIT_DIV, S_EMIT
   } seq_type;

   typedef struct packed {
      logic        chk_target;
      src_a_type   src_a;
      src_b_type   src_b;
      logic        sub;
      logic        clamp;
      dst_type     dst;
      mul_sel_type mul;
      fx_dst_type  fx_dst;
      logic        div_start;
      logic        save_prev;
      seq_type     seq;
   } ucw_type;

   localparam ucw_type UC_NOP = '{
      chk_target: 1'b0, src_a: A_ZERO, src_b: B_ZERO, sub: 1'b0, clamp: 1'b0,
      dst: D_NONE, mul: M_NONE, fx_dst: F_NONE, div_start: 1'b0,
      save_prev: 1'b0, seq: S_NEXT
   };

   function automatic ucw_type ucode(input logic [PC_W-1:0] pc);
      ucw_type w;
      w = UC_NOP;
      unique case (pc)
         4'd0: begin
            w.chk_target = 1'b1;
            w.src_a = A_TGT; w.src_b = B_MEAS; w.sub = 1'b1; w.dst = D_ERR;
         end
         4'd1: w.mul = M_P_ERR;
         4'd2: w.mul = M_ERR_TS;
         4'd3: begin
            w.fx_dst = F_PTERM;
            w.src_a = A_ERR; w.src_b = B_PREV; w.sub = 1'b1; w.dst = D_DIFF;
         end
         4'd4: begin
            w.src_a = A_INTEG; w.src_b = B_FX; w.clamp = 1'b1; w.dst = D_INTEG;
            w.mul = M_D_DIFF;
         end
         4'd5: begin
            w.div_start = 1'b1; w.save_prev = 1'b1; w.mul = M_I_INTEG;
         end
         4'd6: w = UC_NOP;
         4'd7: w.fx_dst = F_ITERM;
         4'd8: w.seq = S_WAIT_DIV;
         4'd9: begin
            w.src_a = A_MEAS_OR_ZERO; w.src_b = B_PTERM; w.dst = D_ACC;
         end
         4'd10: begin
            w.src_a = A_ACC; w.src_b = B_ITERM; w.dst = D_ACC;
         end
         4'd11: begin
            w.src_a = A_ACC; w.src_b = B_DERIV; w.clamp = 1'b1; w.dst = D_ACC;
         end
         4'd12: w.seq = S_EMIT;
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(DATA_MAX);
      lo = PROD_W'(DATA_MIN);
      if (v > hi) begin
         return DATA_MAX;
      end else if (v < lo) begin
         return DATA_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

FILE: rtl/pid_controller_clamped_unit.sv
// ----------------------------------------------------------------------------
// Clamped PID controller
// Microcoded sequencer over one multiplier, one saturating adder and a
// radix-2 divider computing one clamped Q16.16 PID output per item.
// ----------------------------------------------------------------------------
// The req channel takes a target and a measured value; the rsp channel
// returns one drive value per item. Both use valid and ready. Registers are
// to be written through the csr port (write enable, index, data) only while
// idle; the block itself does not enforce this. One item runs through a
// 13-step control program. The derivative division produces one quotient
// bit a cycle, unless its quotient overflows or its numerator is zero, in
// which case it finishes at once. The next item can be taken from the cycle
// after the program has placed its result in the output register, so a new
// item is never accepted while one is still in progress.
// Reset clears the gains, limits, mode, the stored target, integral and
// previous error, and sets the time step to 1.0.
// A stalled receiver holds the result in the output register; the program
// waits at its last step until that register is free.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_unit_macros.svh"

module pid_controller_clamped_unit
   import pidc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_target,
   input  logic signed [DATA_W-1:0] req_measured,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_drive,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   logic signed [DATA_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [DATA_W-1:0] lower_ff, upper_ff;
   logic [TS_W-1:0]          ts_ff;
   logic                     mode_ff;

   logic signed [DATA_W-1:0] lt_ff, integ_ff, prev_ff;
   logic signed [DATA_W-1:0] tgt_ff, meas_ff;
   logic signed [DATA_W-1:0] err_ff, diff_ff, pterm_ff, iterm_ff, acc_ff, deriv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] fx_ff, fx_in;

   logic                     run_ff;
   logic [PC_W-1:0]          pc_ff;
   ucw_type                  uc;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff;

   logic                     div_busy_ff, div_neg_ff;
   logic [TS_W-1:0]          div_rem_ff;
   logic [DATA_W-1:0]        div_lo_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;

   logic signed [DATA_W-1:0] a_val, b_val, alu_res, alu_sat;
   logic signed [DATA_W:0]   alu_sum;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic                     req_acc, can_load;

   logic [PROD_W-1:0]        d_mag;
   logic                     d_neg, d_zero, d_ovf;
   logic [TS_W:0]            d_trial;
   logic                     d_ge;
   logic [TS_W-1:0]          d_rem_in;
   logic [DATA_W-1:0]        d_lo_in;
   logic signed [DATA_W-1:0] d_result;

   assign uc        = ucode(pc_ff);
   assign req_ready = !run_ff;
   assign req_acc   = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_comb begin
      unique case (uc.src_a)
         A_TGT:          a_val = tgt_ff;
         A_ERR:          a_val = err_ff;
         A_INTEG:        a_val = integ_ff;
         A_ACC:          a_val = acc_ff;
         A_MEAS_OR_ZERO: a_val = (mode_ff == MODE_ABSOLUTE) ? meas_ff : '0;
         default:        a_val = '0;
      endcase
      unique case (uc.src_b)
         B_MEAS:  b_val = meas_ff;
         B_PREV:  b_val = prev_ff;
         B_FX:    b_val = fx_ff;
         B_PTERM: b_val = pterm_ff;
         B_ITERM: b_val = iterm_ff;
         B_DERIV: b_val = deriv_ff;
         default: b_val = '0;
      endcase
      if (uc.sub) begin
         alu_sum = {a_val[DATA_W-1], a_val} - {b_val[DATA_W-1], b_val};
      end else begin
         alu_sum = {a_val[DATA_W-1], a_val} + {b_val[DATA_W-1], b_val};
      end
      alu_sat = sat_data(PROD_W'(alu_sum));
      alu_res = alu_sat;
      if (uc.clamp) begin
         priority if (alu_sat < lower_ff) begin
            alu_res = lower_ff;
         end else if (alu_sat > upper_ff) begin
            alu_res = upper_ff;
         end
      end
   end

   always_comb begin
      unique case (uc.mul)
         M_P_ERR: begin
            mul_a = gain_p_ff; mul_b = err_ff;
         end
         M_ERR_TS: begin
            mul_a = err_ff; mul_b = signed'({1'b0, ts_ff});
         end
         M_D_DIFF: begin
            mul_a = gain_d_ff; mul_b = diff_ff;
         end
         M_I_INTEG: begin
            mul_a = gain_i_ff; mul_b = integ_ff;
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
   end

   assign fx_in = sat_data(prod_ff >>> FRAC_W);

   always_comb begin
      d_neg    = prod_ff[PROD_W-1];
      d_mag    = d_neg ? (~prod_ff + 1'b1) : prod_ff;
      d_zero   = (d_mag == '0);
      d_ovf    = (d_mag[PROD_W-1:DATA_W] >= {1'b0, ts_ff});
      d_trial  = {div_rem_ff, div_lo_ff[DATA_W-1]};
      d_ge     = (d_trial >= {1'b0, ts_ff});
      d_rem_in = d_ge ? TS_W'(d_trial - {1'b0, ts_ff}) : d_trial[TS_W-1:0];
      d_lo_in  = {div_lo_ff[DATA_W-2:0], d_ge};
      if (div_neg_ff) begin
         d_result = (d_lo_in > DATA_W'(DATA_MIN)) ? DATA_MIN : signed'(~d_lo_in + 1'b1);
      end else begin
         d_result = d_lo_in[DATA_W-1] ? DATA_MAX : signed'(d_lo_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         ts_ff     <= TIME_STEP_RESET;
         lower_ff  <= '0;
         upper_ff  <= '0;
         mode_ff   <= MODE_ABSOLUTE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:      gain_p_ff <= signed'(csr_wdata);
            CSR_GAIN_I:      gain_i_ff <= signed'(csr_wdata);
            CSR_GAIN_D:      gain_d_ff <= signed'(csr_wdata);
            CSR_TIME_STEP:   ts_ff     <= csr_wdata[TS_W-1:0];
            CSR_LOWER_LIMIT: lower_ff  <= signed'(csr_wdata);
            CSR_UPPER_LIMIT: upper_ff  <= signed'(csr_wdata);
            CSR_OUTPUT_MODE: mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= '0;
      end else if (req_acc) begin
         run_ff <= 1'b1;
         pc_ff  <= '0;
      end else if (run_ff) begin
         unique case (uc.seq)
            S_NEXT: pc_ff <= pc_ff + 1'b1;
            S_WAIT_DIV: begin
               if (!div_busy_ff) begin
                  pc_ff <= pc_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (can_load) begin
                  run_ff <= 1'b0;
               end
            end
            default: pc_ff <= pc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         tgt_ff  <= req_target;
         meas_ff <= req_measured;
      end
      fx_ff <= fx_in;
      if (run_ff && uc.mul != M_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
      if (run_ff) begin
         unique case (uc.fx_dst)
            F_PTERM: pterm_ff <= fx_ff;
            F_ITERM: iterm_ff <= fx_ff;
            default: ;
         endcase
         unique case (uc.dst)
            D_ERR:  err_ff  <= alu_res;
            D_DIFF: diff_ff <= alu_res;
            D_ACC:  acc_ff  <= alu_res;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff    <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else if (run_ff) begin
         if (uc.chk_target && tgt_ff != lt_ff) begin
            lt_ff    <= tgt_ff;
            integ_ff <= '0;
            prev_ff  <= '0;
         end
         if (uc.dst == D_INTEG) begin
            integ_ff <= alu_res;
         end
         if (uc.save_prev) begin
            prev_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (run_ff && uc.div_start) begin
         div_busy_ff <= !d_zero && !d_ovf;
      end else if (div_busy_ff && div_cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff && uc.div_start) begin
         div_neg_ff <= d_neg;
         div_rem_ff <= d_mag[DATA_W+TS_W-1:DATA_W];
         div_lo_ff  <= d_mag[DATA_W-1:0];
         div_cnt_ff <= '0;
         if (d_zero) begin
            deriv_ff <= '0;
         end else if (d_ovf) begin
            deriv_ff <= d_neg ? DATA_MIN : DATA_MAX;
         end
      end else if (div_busy_ff) begin
         div_rem_ff <= d_rem_in;
         div_lo_ff  <= d_lo_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (div_cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            deriv_ff <= d_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (run_ff && uc.seq == S_EMIT && can_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff && uc.seq == S_EMIT && can_load) begin
         rsp_drive_ff <= acc_ff;
      end
   end

   `PIDC_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, run_ff && pc_ff == '0)
   `PIDC_ASSERT_SAME(a_div_in_run, div_busy_ff, run_ff && !req_ready)
   `PIDC_ASSERT_SAME(a_pc_range, run_ff, pc_ff <= PC_LAST)
   `PIDC_ASSERT_NEXT(a_integ_clamped, run_ff && pc_ff == PC_INTEG && !csr_we && lower_ff <= upper_ff, integ_ff >= lower_ff && integ_ff <= upper_ff)
   `PIDC_ASSERT_NEXT(a_emit_loads, run_ff && pc_ff == PC_LAST && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && !run_ff)

endmodule

FILE: bench/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// PID controller drive checker
// Watches the register port and both channels of the clamped PID controller,
// predicts the drive value of every accepted item and compares each returned
// result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pid_drive_checker
   import pidc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_target,
   input  logic signed [DATA_W-1:0] req_measured,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_drive,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   output int                       fail_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [DATA_W-1:0] kp, ki, kd, lim_lo, lim_hi;
   logic [TS_W-1:0]          step;
   logic                     out_mode;
   logic signed [DATA_W-1:0] held_target, integ, prev_err;
   logic signed [DATA_W-1:0] drive_expected[$];
   int                       misses = 0;

   function automatic longint sat_word(input longint v);
      if (v > longint'(DATA_MAX)) begin
         return longint'(DATA_MAX);
      end else if (v < longint'(DATA_MIN)) begin
         return longint'(DATA_MIN);
      end
      return v;
   endfunction

   // Exact product, floored back to Q16.16, then saturated.
   function automatic longint fx_product(input longint a, input longint b);
      longint p;
      p = a * b;
      return sat_word(p >>> FRAC_W);
   endfunction

   function automatic longint limit_range(input longint v);
      if (v < lim_lo) begin
         return lim_lo;
      end else if (v > lim_hi) begin
         return lim_hi;
      end
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] next_drive(
      input logic signed [DATA_W-1:0] tgt,
      input logic signed [DATA_W-1:0] meas);
      longint t, m, ts, e, pt, it, df, num, dv, s;
      t  = tgt;
      m  = meas;
      ts = step;
      if (tgt != held_target) begin
         held_target = tgt;
         integ = '0;
         prev_err = '0;
      end
      e   = sat_word(t - m);
      pt  = fx_product(kp, e);
      integ = DATA_W'(limit_range(sat_word(longint'(integ) + fx_product(e, ts))));
      it  = fx_product(ki, integ);
      df  = sat_word(e - longint'(prev_err));
      num = longint'(kd) * df;
      // A zero time step saturates toward the sign of the numerator.
      if (ts == 0) begin
         dv = (num > 0) ? longint'(DATA_MAX) : ((num < 0) ? longint'(DATA_MIN) : 0);
      end else begin
         dv = sat_word(num / ts);
      end
      prev_err = DATA_W'(e);
      if (out_mode == MODE_ABSOLUTE) begin
         s = sat_word(sat_word(sat_word(m + pt) + it) + dv);
      end else begin
         s = sat_word(sat_word(pt + it) + dv);
      end
      s = limit_range(s);
      return s[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic signed [DATA_W-1:0] want;
      if (reset) begin
         kp = '0;
         ki = '0;
         kd = '0;
         step = TIME_STEP_RESET;
         lim_lo = '0;
         lim_hi = '0;
         out_mode = MODE_ABSOLUTE;
         held_target = '0;
         integ = '0;
         prev_err = '0;
         drive_expected.delete();
         pending <= 0;
         fail_count <= misses;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P:      kp = csr_wdata;
               CSR_GAIN_I:      ki = csr_wdata;
               CSR_GAIN_D:      kd = csr_wdata;
               CSR_TIME_STEP:   step = csr_wdata[TS_W-1:0];
               CSR_LOWER_LIMIT: lim_lo = csr_wdata;
               CSR_UPPER_LIMIT: lim_hi = csr_wdata;
               CSR_OUTPUT_MODE: out_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_expected.size() == 0) begin
               misses++;
               if (misses <= 10) begin
                  $display("unexpected drive result %0d at %0t", rsp_drive, $realtime);
               end
            end else begin
               want = drive_expected.pop_front();
               if (rsp_drive !== want) begin
                  misses++;
                  if (misses <= 10) begin
                     $display("drive mismatch: expected %0d, got %0d at %0t",
                              want, rsp_drive, $realtime);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            drive_expected.push_back(next_drive(req_target, req_measured));
         end
         pending <= drive_expected.size();
         fail_count <= misses;
      end
   end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Drives directed and random setpoint and feedback items through the clamped
// PID controller under changing gains, limits, time steps and output modes,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import pidc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_target = '0;
   logic signed [DATA_W-1:0] req_measured = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_drive;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_GAIN_P;
   logic [DATA_W-1:0]        csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   sender_idle = 25;
   int   recv_idle = 84;
   logic hold_go = 1'b0;
   logic hold_off = 1'b0;

   pid_controller_clamped_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target   (req_target),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pid_drive_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target   (req_target),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("FAIL pid_controller_clamped_unit");
      $finish;
   end

   function automatic logic [DATA_W-1:0] any_word();
      case ($urandom_range(0, 7))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] near_word(input int unsigned span);
      return DATA_W'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic send_item(input logic [DATA_W-1:0] tgt, input logic [DATA_W-1:0] meas);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target <= tgt;
      req_measured <= meas;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic set_controls(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                               input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] ts,
                               input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                               input logic [DATA_W-1:0] mode);
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_TIME_STEP, ts);
      write_reg(CSR_LOWER_LIMIT, lo);
      write_reg(CSR_UPPER_LIMIT, hi);
      write_reg(CSR_OUTPUT_MODE, mode);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_gain();
      return ($urandom_range(0, 5) == 0) ? any_word() : near_word(32'h0004_0000);
   endfunction

   task automatic random_controls();
      logic [DATA_W-1:0] ts, lo, hi, swap;
      case ($urandom_range(0, 7))
         0: ts = '0;
         1: ts = 32'h7FFF_FFFF;
         2: ts = $urandom();
         default: ts = $urandom_range(1, 32'h0004_0000);
      endcase
      lo = -$urandom_range(0, 32'h0200_0000);
      hi = $urandom_range(0, 32'h0200_0000);
      case ($urandom_range(0, 7))
         0: begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         1: begin
            lo = DATA_MIN;
            hi = DATA_MAX;
         end
         2: begin
            lo = any_word();
            hi = any_word();
         end
         default: ;
      endcase
      set_controls(random_gain(), random_gain(), random_gain(), ts, lo, hi, $urandom());
   endtask

   initial begin
      int                sent;
      int                len;
      logic [DATA_W-1:0] tgt;
      logic [DATA_W-1:0] meas;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item('0, '0);
      send_item(DATA_MAX, DATA_MIN);
      wait_idle();

      set_controls(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                   32'hFF9C_0000, 32'h0064_0000, DATA_W'(MODE_ABSOLUTE));
      repeat (3) send_item(32'h0005_0000, 32'h0001_0000);
      send_item(32'h0005_0000, 32'h0006_0000);
      send_item(DATA_MAX, DATA_MIN);
      send_item(DATA_MIN, DATA_MAX);
      send_item(DATA_MAX, DATA_MAX);
      send_item(DATA_MIN, DATA_MIN);
      send_item('1, '0);
      send_item('0, '1);
      wait_idle();

      // Zero time step with extreme gains in delta mode.
      set_controls(DATA_MAX, DATA_MIN, DATA_MAX, '0, DATA_MIN, DATA_MAX,
                   DATA_W'(!MODE_ABSOLUTE));
      send_item(32'd1, 32'd0);
      send_item(32'd1, 32'd1);
      send_item(32'd2, 32'd2);
      send_item(DATA_MAX, DATA_MIN);
      send_item(DATA_MIN, DATA_MAX);
      wait_idle();

      // Lower limit above the upper limit.
      set_controls(DATA_MIN, DATA_MAX, DATA_MIN, 32'h7FFF_FFFF, 32'h000A_0000,
                   32'hFFF6_0000, DATA_W'(MODE_ABSOLUTE));
      send_item('0, '0);
      send_item(DATA_MAX, '0);
      send_item(DATA_MIN, DATA_MAX);
      send_item(32'd3, '0);

      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               sender_idle = 25;
               recv_idle = 84;
            end
            1: begin
               sender_idle = 84;
               recv_idle = 25;
            end
            default: begin
               sender_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (int round = 0; round < 7; round++) begin
            wait_idle();
            random_controls();
            if (pass == 2 && round == 3) begin
               hold_go <= 1'b1;
            end
            sent = 0;
            while (sent < 100) begin
               if ($urandom_range(0, 9) < 8) begin
                  tgt = ($urandom_range(0, 7) == 0) ? any_word() : near_word(32'h0100_0000);
                  len = $urandom_range(1, 12);
                  for (int k = 0; k < len; k++) begin
                     meas = ($urandom_range(0, 3) == 0) ? any_word()
                                                        : tgt + near_word(32'h0004_0000);
                     send_item(tgt, meas);
                  end
                  sent += len;
               end else begin
                  send_item(any_word(), $urandom());
                  sent++;
               end
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("PASS pid_controller_clamped_unit");
      end else begin
         $display("FAIL pid_controller_clamped_unit");
      end
      $finish;
   end

endmodule
